// ----- rtl/core/uartrb_pkg.sv -----
`default_nettype none
package uartrb_pkg;

  typedef enum logic [1:0] {
    OP_HOST_WRITE = 2'd0,
    OP_HOST_READ  = 2'd1,
    OP_TX_READY   = 2'd2,
    OP_RX_BYTE    = 2'd3
  } op_t;

  localparam int unsigned PendW = 6;

  typedef struct packed {
    logic             send_valid;
    logic             read_en;
    logic             recv_hit;
    logic [PendW-1:0] rx_pending;
    logic [PendW-1:0] tx_pending;
    logic             tx_irq_enabled;
    logic             write_accepted;
    logic             rx_overflow;
  } res_t;

  typedef struct packed {
    logic       we;
    logic       re;
    logic [7:0] wdata;
  } ram_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/uart_tx_rx_ring_buffers.sv -----
`default_nettype none
// Channel  Direction  Handshake            Payload
// in       sink       in_valid/in_stall    opcode, data_byte, line_error
// out      source     out_valid/out_stall  send_valid, send_byte, read_byte,
//                                          rx_pending, tx_pending,
//                                          tx_irq_enabled, write_accepted,
//                                          rx_overflow
// One transaction per cycle while in_stall is low. Each result waits in s1,
// with the registered RAM read port, then moves to the output registers.
// Two result registers let one more transaction in while a result is held.
// Reset clears pointers, counts and the receive written-bits; interrupt on.
// in_stall rises only while both result registers are full and out is stalled.
module uart_tx_rx_ring_buffers #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] data_byte,
  input  wire logic       line_error,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            send_valid,
  output logic      [7:0] send_byte,
  output logic      [7:0] read_byte,
  output logic      [5:0] rx_pending,
  output logic      [5:0] tx_pending,
  output logic            tx_irq_enabled,
  output logic            write_accepted,
  output logic            rx_overflow
);
  import uartrb_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  logic          accept;
  ram_ctl_t      tx_ctl, rx_ctl;
  logic [PW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
  logic [7:0]    tx_q, rx_q;
  res_t          res;

  assign accept = in_valid && !in_stall;

  uartrb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (opcode),
    .data_byte  (data_byte),
    .line_error (line_error),
    .tx_ctl     (tx_ctl),
    .tx_waddr   (tx_waddr),
    .tx_raddr   (tx_raddr),
    .rx_ctl     (rx_ctl),
    .rx_waddr   (rx_waddr),
    .rx_raddr   (rx_raddr),
    .res        (res)
  );

  uartrb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_ctl.we),
    .waddr (tx_waddr),
    .wdata (tx_ctl.wdata),
    .re    (tx_ctl.re),
    .raddr (tx_raddr),
    .rdata (tx_q)
  );

  uartrb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_ctl.we),
    .waddr (rx_waddr),
    .wdata (rx_ctl.wdata),
    .re    (rx_ctl.re),
    .raddr (rx_raddr),
    .rdata (rx_q)
  );

  uartrb_outq u_outq (
    .clk            (clk),
    .rst            (rst),
    .load           (accept),
    .res            (res),
    .tx_q           (tx_q),
    .rx_q           (rx_q),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .send_valid     (send_valid),
    .send_byte      (send_byte),
    .read_byte      (read_byte),
    .rx_pending     (rx_pending),
    .tx_pending     (tx_pending),
    .tx_irq_enabled (tx_irq_enabled),
    .write_accepted (write_accepted),
    .rx_overflow    (rx_overflow)
  );

  a_tx_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(tx_ctl.we && tx_ctl.re))
    else $error("transmit RAM written and read by one transaction");

  a_rx_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(rx_ctl.we && rx_ctl.re))
    else $error("receive RAM written and read by one transaction");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  a_send_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !send_valid) |-> (send_byte == 8'h00))
    else $error("send_byte nonzero without send_valid");

endmodule
`default_nettype wire

// ----- rtl/core/uartrb_ram.sv -----
`default_nettype none
module uartrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/uartrb_ctrl.sv -----
`default_nettype none
module uartrb_ctrl #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     accept,
  input  wire logic [1:0]               opcode,
  input  wire logic [7:0]               data_byte,
  input  wire logic                     line_error,
  output uartrb_pkg::ram_ctl_t          tx_ctl,
  output logic      [$clog2(DEPTH)-1:0] tx_waddr,
  output logic      [$clog2(DEPTH)-1:0] tx_raddr,
  output uartrb_pkg::ram_ctl_t          rx_ctl,
  output logic      [$clog2(DEPTH)-1:0] rx_waddr,
  output logic      [$clog2(DEPTH)-1:0] rx_raddr,
  output uartrb_pkg::res_t              res
);
  import uartrb_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CntFull = CW'(DEPTH);
  localparam logic [CW-1:0] CntTxMax = CW'(DEPTH - 1);

  logic [PW-1:0]    tx_put, tx_put_next, tx_take, tx_take_next;
  logic [PW-1:0]    rx_put, rx_put_next, rx_take, rx_take_next;
  logic [CW-1:0]    tx_cnt, tx_cnt_next, rx_cnt, rx_cnt_next;
  logic             irq_on, irq_on_next;
  logic [DEPTH-1:0] rx_written, rx_written_next;
  op_t              op;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PtrLast) ? '0 : p + PW'(1);
  endfunction

  assign op = op_t'(opcode);

  always_comb begin
    tx_put_next     = tx_put;
    tx_take_next    = tx_take;
    tx_cnt_next     = tx_cnt;
    rx_put_next     = rx_put;
    rx_take_next    = rx_take;
    rx_cnt_next     = rx_cnt;
    irq_on_next     = irq_on;
    rx_written_next = rx_written;
    tx_ctl          = '{we: 1'b0, re: 1'b0, wdata: data_byte};
    rx_ctl          = '{we: 1'b0, re: 1'b0, wdata: data_byte};
    res             = '0;
    if (accept) begin
      unique case (op)
        OP_HOST_WRITE: begin
          if (tx_cnt < CntTxMax) begin
            tx_ctl.we          = 1'b1;
            tx_put_next        = ptr_inc(tx_put);
            tx_cnt_next        = tx_cnt + CW'(1);
            irq_on_next        = 1'b1;
            res.write_accepted = 1'b1;
          end
        end
        OP_HOST_READ: begin
          rx_ctl.re    = 1'b1;
          res.read_en  = 1'b1;
          res.recv_hit = rx_written[rx_take];
          if (rx_cnt != '0) begin
            rx_take_next = ptr_inc(rx_take);
            rx_cnt_next  = rx_cnt - CW'(1);
          end
        end
        OP_TX_READY: begin
          if (irq_on) begin
            if (tx_cnt != '0) begin
              tx_ctl.re      = 1'b1;
              res.send_valid = 1'b1;
              tx_take_next   = ptr_inc(tx_take);
              tx_cnt_next    = tx_cnt - CW'(1);
            end else begin
              irq_on_next = 1'b0;
            end
          end
        end
        OP_RX_BYTE: begin
          if (!line_error) begin
            if (rx_cnt >= CntFull) begin
              res.rx_overflow = 1'b1;
            end else begin
              rx_ctl.we               = 1'b1;
              rx_written_next[rx_put] = 1'b1;
              rx_put_next             = ptr_inc(rx_put);
              rx_cnt_next             = rx_cnt + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
    res.rx_pending     = PendW'(rx_cnt_next);
    res.tx_pending     = PendW'(tx_cnt_next);
    res.tx_irq_enabled = irq_on_next;
  end

  assign tx_waddr = tx_put;
  assign tx_raddr = tx_take;
  assign rx_waddr = rx_put;
  assign rx_raddr = rx_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_put     <= '0;
      tx_take    <= '0;
      tx_cnt     <= '0;
      rx_put     <= '0;
      rx_take    <= '0;
      rx_cnt     <= '0;
      irq_on     <= 1'b1;
      rx_written <= '0;
    end else begin
      tx_put     <= tx_put_next;
      tx_take    <= tx_take_next;
      tx_cnt     <= tx_cnt_next;
      rx_put     <= rx_put_next;
      rx_take    <= rx_take_next;
      rx_cnt     <= rx_cnt_next;
      irq_on     <= irq_on_next;
      rx_written <= rx_written_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/uartrb_outq.sv -----
`default_nettype none
module uartrb_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire uartrb_pkg::res_t res,
  input  wire logic [7:0]       tx_q,
  input  wire logic [7:0]       rx_q,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  send_valid,
  output logic      [7:0]       send_byte,
  output logic      [7:0]       read_byte,
  output logic      [5:0]       rx_pending,
  output logic      [5:0]       tx_pending,
  output logic                  tx_irq_enabled,
  output logic                  write_accepted,
  output logic                  rx_overflow
);
  import uartrb_pkg::*;

  logic s1_valid, s1_valid_next, out_valid_next, move;
  res_t s1;

  assign move     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  always_comb begin
    s1_valid_next  = s1_valid;
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    if (move) begin
      out_valid_next = 1'b1;
      s1_valid_next  = 1'b0;
    end
    if (load) begin
      s1_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= res;
    end
    if (move) begin
      send_valid     <= s1.send_valid;
      send_byte      <= s1.send_valid ? tx_q : 8'h00;
      read_byte      <= (s1.read_en && s1.recv_hit) ? rx_q : 8'h00;
      rx_pending     <= s1.rx_pending;
      tx_pending     <= s1.tx_pending;
      tx_irq_enabled <= s1.tx_irq_enabled;
      write_accepted <= s1.write_accepted;
      rx_overflow    <= s1.rx_overflow;
    end
  end

endmodule
`default_nettype wire
